// ----- rtl/core/ihd_pkg.sv -----
// shared constants, codes and state type for the indexed min-heap
package ihd_pkg;

   localparam int unsigned KEY_BITS        = 10;
   localparam int unsigned REQ_BITS        = 2;
   localparam int unsigned VAL_PORT_BITS   = 16;
   localparam int unsigned STATUS_BITS     = 2;
   localparam int unsigned COUNT_PORT_BITS = 11;

   localparam int unsigned MAX_KEYS_DEF    = 1024;
   localparam int unsigned VALUE_BITS_DEF  = 16;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_INSERT    = 2'd0,
      REQ_DECREMENT = 2'd1,
      REQ_POP       = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_DUP   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_DEC_CMP,
      S_UP,
      S_POP_READ,
      S_DN_SEL,
      S_DN_CMP,
      S_DONE
   } state_type;

endpackage

// ----- rtl/core/ihd_heap_ram.sv -----
// heap slot memory: key/value per slot, two registered read ports, one write port
module ihd_heap_ram #(
   parameter int unsigned DEPTH      = ihd_pkg::MAX_KEYS_DEF,
   parameter int unsigned SLOT_BITS  = $clog2(ihd_pkg::MAX_KEYS_DEF),
   parameter int unsigned VALUE_BITS = ihd_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic [SLOT_BITS-1:0]          rd_addr_a,
   input  logic [SLOT_BITS-1:0]          rd_addr_b,
   output logic [ihd_pkg::KEY_BITS-1:0]  rd_key_a,
   output logic [VALUE_BITS-1:0]         rd_val_a,
   output logic [ihd_pkg::KEY_BITS-1:0]  rd_key_b,
   output logic [VALUE_BITS-1:0]         rd_val_b,
   input  logic                          wr_en,
   input  logic [SLOT_BITS-1:0]          wr_addr,
   input  logic [ihd_pkg::KEY_BITS-1:0]  wr_key,
   input  logic [VALUE_BITS-1:0]         wr_val
);
   import ihd_pkg::*;

   localparam int unsigned ENTRY_BITS = KEY_BITS + VALUE_BITS;

   logic [ENTRY_BITS-1:0] heap_mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_a_ff;
   logic [ENTRY_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= {wr_key, wr_val};
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   assign rd_key_a = rd_a_ff[ENTRY_BITS-1:VALUE_BITS];
   assign rd_val_a = rd_a_ff[VALUE_BITS-1:0];
   assign rd_key_b = rd_b_ff[ENTRY_BITS-1:VALUE_BITS];
   assign rd_val_b = rd_b_ff[VALUE_BITS-1:0];

endmodule

// ----- rtl/core/ihd_pos_ram.sv -----
// key-to-slot position table with present flag and clearing pass after reset
module ihd_pos_ram #(
   parameter int unsigned SLOT_BITS = $clog2(ihd_pkg::MAX_KEYS_DEF)
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          ready,
   input  logic [ihd_pkg::KEY_BITS-1:0]  rd_addr,
   output logic                          rd_present,
   output logic [SLOT_BITS-1:0]          rd_slot,
   input  logic                          wr_en,
   input  logic [ihd_pkg::KEY_BITS-1:0]  wr_addr,
   input  logic                          wr_present,
   input  logic [SLOT_BITS-1:0]          wr_slot
);
   import ihd_pkg::*;

   localparam int unsigned KEY_DEPTH = 1 << KEY_BITS;

   logic [SLOT_BITS:0]    pos_mem [KEY_DEPTH];
   logic [SLOT_BITS:0]    rd_data_ff;
   logic                  clearing_ff;
   logic                  clearing_in;
   logic [KEY_BITS-1:0]   clr_addr_ff;
   logic [KEY_BITS-1:0]   clr_addr_in;
   logic                  mem_we;
   logic [KEY_BITS-1:0]   mem_waddr;
   logic [SLOT_BITS:0]    mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + KEY_BITS'(1);
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // the sweep owns the write port until every key reads absent
   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? '0 : {wr_present, wr_slot};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pos_mem[rd_addr];
   end

   assign ready      = !clearing_ff;
   assign rd_present = rd_data_ff[SLOT_BITS];
   assign rd_slot    = rd_data_ff[SLOT_BITS-1:0];

endmodule

// ----- rtl/core/indexed_min_heap_decrement.sv -----
// indexed min-heap top level: request sequencer, shared value comparator and the two memories
// insert and decrement climb one level per cycle on the shared comparator; pop sinks the moved
//   entry to a leaf or until a compare stops it, two compares per level; the last entry needs no sift
// throughput: one request at a time; busy drops the cycle after the result strobe
// reset: busy stays high while the position table is swept to absent
// the result strobe lasts one cycle and cannot be held off by the receiver
module indexed_min_heap_decrement #(
   parameter int unsigned MAX_KEYS   = ihd_pkg::MAX_KEYS_DEF,
   parameter int unsigned VALUE_BITS = ihd_pkg::VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ihd_pkg::REQ_BITS-1:0]         req_type,
   input  logic [ihd_pkg::KEY_BITS-1:0]         req_item_key,
   input  logic [ihd_pkg::VAL_PORT_BITS-1:0]    req_item_value,
   output logic                                 rsp_valid,
   output logic [ihd_pkg::KEY_BITS-1:0]         rsp_out_key,
   output logic [ihd_pkg::VAL_PORT_BITS-1:0]    rsp_out_value,
   output logic [ihd_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [ihd_pkg::COUNT_PORT_BITS-1:0]  rsp_entry_count
);
   import ihd_pkg::*;

   localparam int unsigned SLOT_BITS = $clog2(MAX_KEYS);
   localparam int unsigned CNT_BITS  = $clog2(MAX_KEYS + 1);

   state_type                 state_ff, state_in;
   req_code_type              op_ff, op_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [VALUE_BITS-1:0]     val_ff, val_in;
   logic [CNT_BITS-1:0]       size_ff, size_in;
   logic [SLOT_BITS-1:0]      slot_ff, slot_in;
   logic [KEY_BITS-1:0]       mov_key_ff, mov_key_in;
   logic [VALUE_BITS-1:0]     mov_val_ff, mov_val_in;
   logic [KEY_BITS-1:0]       ch_key_ff, ch_key_in;
   logic [VALUE_BITS-1:0]     ch_val_ff, ch_val_in;
   logic [SLOT_BITS-1:0]      ch_slot_ff, ch_slot_in;
   logic [KEY_BITS-1:0]       out_key_ff, out_key_in;
   logic [VAL_PORT_BITS-1:0]  out_val_ff, out_val_in;
   status_type                status_ff, status_in;

   // memory ports
   logic [SLOT_BITS-1:0]      heap_rd_a, heap_rd_b;
   logic [KEY_BITS-1:0]       heap_key_a, heap_key_b;
   logic [VALUE_BITS-1:0]     heap_val_a, heap_val_b;
   logic                      heap_we;
   logic [SLOT_BITS-1:0]      heap_wa;
   logic [KEY_BITS-1:0]       heap_wk;
   logic [VALUE_BITS-1:0]     heap_wv;
   logic                      pos_ready;
   logic [KEY_BITS-1:0]       pos_rd;
   logic                      pos_present;
   logic [SLOT_BITS-1:0]      pos_slot;
   logic                      pos_we;
   logic [KEY_BITS-1:0]       pos_wa;
   logic                      pos_wp;
   logic [SLOT_BITS-1:0]      pos_ws;

   // shared comparator
   logic [VALUE_BITS-1:0]     cmp_a, cmp_b;
   logic                      val_lt;

   logic                      req_key_ok;
   logic                      heap_full;
   logic                      heap_empty;
   logic                      pos_in_heap;
   logic [SLOT_BITS:0]        size_w;
   logic [SLOT_BITS:0]        c1_w, c2_w;
   logic                      dn_has_c1;
   logic                      dn_pick_b;
   logic                      up_stop;

   ihd_heap_ram #(
      .DEPTH      (MAX_KEYS),
      .SLOT_BITS  (SLOT_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_heap_ram (
      .clock     (clock),
      .rd_addr_a (heap_rd_a),
      .rd_addr_b (heap_rd_b),
      .rd_key_a  (heap_key_a),
      .rd_val_a  (heap_val_a),
      .rd_key_b  (heap_key_b),
      .rd_val_b  (heap_val_b),
      .wr_en     (heap_we),
      .wr_addr   (heap_wa),
      .wr_key    (heap_wk),
      .wr_val    (heap_wv)
   );

   ihd_pos_ram #(
      .SLOT_BITS (SLOT_BITS)
   ) u_pos_ram (
      .clock      (clock),
      .reset      (reset),
      .ready      (pos_ready),
      .rd_addr    (pos_rd),
      .rd_present (pos_present),
      .rd_slot    (pos_slot),
      .wr_en      (pos_we),
      .wr_addr    (pos_wa),
      .wr_present (pos_wp),
      .wr_slot    (pos_ws)
   );

   always_comb begin
      unique case (state_ff)
         S_DEC_CMP: begin
            cmp_a = val_ff;
            cmp_b = heap_val_a;
         end
         S_UP: begin
            cmp_a = mov_val_ff;
            cmp_b = heap_val_a;
         end
         S_DN_SEL: begin
            cmp_a = heap_val_b;
            cmp_b = heap_val_a;
         end
         S_DN_CMP: begin
            cmp_a = ch_val_ff;
            cmp_b = mov_val_ff;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   assign val_lt = cmp_a < cmp_b;

   assign req_key_ok  = 32'(req_item_key) < 32'(MAX_KEYS);
   assign heap_full   = size_ff >= CNT_BITS'(MAX_KEYS);
   assign heap_empty  = size_ff == '0;
   assign size_w      = (SLOT_BITS + 1)'(size_ff);
   assign pos_in_heap = {1'b0, pos_slot} < size_w;
   assign c1_w        = {slot_ff, 1'b1};
   assign c2_w        = c1_w + (SLOT_BITS + 1)'(1);
   assign dn_has_c1   = c1_w < size_w;
   assign dn_pick_b   = (c2_w < size_w) && val_lt;
   assign up_stop     = (slot_ff == '0) || !val_lt;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (pos_ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_INSERT:    state_in = (req_key_ok && !heap_full) ? S_LOOKUP : S_DONE;
                  REQ_DECREMENT: state_in = req_key_ok ? S_LOOKUP : S_DONE;
                  REQ_POP:       state_in = heap_empty ? S_DONE : S_POP_READ;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_LOOKUP: begin
            if (op_ff == REQ_INSERT) begin
               state_in = pos_present ? S_DONE : S_UP;
            end else begin
               state_in = (pos_present && pos_in_heap) ? S_DEC_CMP : S_DONE;
            end
         end
         S_DEC_CMP:  state_in = val_lt ? S_UP : S_DONE;
         S_UP:       state_in = up_stop ? S_DONE : S_UP;
         S_POP_READ: state_in = (size_ff == CNT_BITS'(1)) ? S_DONE : S_DN_SEL;
         S_DN_SEL:   state_in = dn_has_c1 ? S_DN_CMP : S_DONE;
         S_DN_CMP:   state_in = val_lt ? S_DN_SEL : S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      size_in    = size_ff;
      slot_in    = slot_ff;
      mov_key_in = mov_key_ff;
      mov_val_in = mov_val_ff;
      ch_key_in  = ch_key_ff;
      ch_val_in  = ch_val_ff;
      ch_slot_in = ch_slot_ff;
      out_key_in = out_key_ff;
      out_val_in = out_val_ff;
      status_in  = status_ff;
      heap_rd_a  = '0;
      heap_rd_b  = '0;
      heap_we    = 1'b0;
      heap_wa    = slot_ff;
      heap_wk    = mov_key_ff;
      heap_wv    = mov_val_ff;
      pos_rd     = req_item_key;
      pos_we     = 1'b0;
      pos_wa     = mov_key_ff;
      pos_wp     = 1'b1;
      pos_ws     = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_code_type'(req_type);
               key_in     = req_item_key;
               val_in     = VALUE_BITS'(req_item_value);
               out_key_in = '0;
               out_val_in = '0;
               status_in  = STATUS_OK;
               if ((req_type == REQ_INSERT) && (!req_key_ok || heap_full)) begin
                  status_in = STATUS_FULL;
               end
               if ((req_type == REQ_POP) && heap_empty) begin
                  status_in = STATUS_EMPTY;
               end
               // top and last entry, used only by pop
               heap_rd_a = '0;
               heap_rd_b = SLOT_BITS'(size_ff - CNT_BITS'(1));
            end
         end
         S_LOOKUP: begin
            if (op_ff == REQ_INSERT) begin
               if (pos_present) begin
                  status_in = STATUS_DUP;
               end else begin
                  size_in    = size_ff + CNT_BITS'(1);
                  mov_key_in = key_ff;
                  mov_val_in = val_ff;
                  slot_in    = SLOT_BITS'(size_ff);
                  heap_rd_a  = SLOT_BITS'((slot_in - SLOT_BITS'(1)) >> 1);
               end
            end else begin
               slot_in   = pos_slot;
               heap_rd_a = pos_slot;
            end
         end
         S_DEC_CMP: begin
            if (val_lt) begin
               mov_key_in = key_ff;
               mov_val_in = heap_val_a - VALUE_BITS'(1);
               heap_rd_a  = SLOT_BITS'((slot_ff - SLOT_BITS'(1)) >> 1);
            end
         end
         S_UP: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (!up_stop) begin
               // parent moves down into the hole
               heap_wk   = heap_key_a;
               heap_wv   = heap_val_a;
               pos_wa    = heap_key_a;
               slot_in   = SLOT_BITS'((slot_ff - SLOT_BITS'(1)) >> 1);
               heap_rd_a = SLOT_BITS'((slot_in - SLOT_BITS'(1)) >> 1);
            end
         end
         S_POP_READ: begin
            out_key_in = heap_key_a;
            out_val_in = VAL_PORT_BITS'(heap_val_a);
            size_in    = size_ff - CNT_BITS'(1);
            pos_we     = 1'b1;
            pos_wa     = heap_key_a;
            pos_wp     = 1'b0;
            pos_ws     = '0;
            mov_key_in = heap_key_b;
            mov_val_in = heap_val_b;
            slot_in    = '0;
            heap_rd_a  = SLOT_BITS'(1);
            heap_rd_b  = SLOT_BITS'(2);
         end
         S_DN_SEL: begin
            if (dn_has_c1) begin
               ch_key_in  = dn_pick_b ? heap_key_b : heap_key_a;
               ch_val_in  = dn_pick_b ? heap_val_b : heap_val_a;
               ch_slot_in = dn_pick_b ? SLOT_BITS'(c2_w) : SLOT_BITS'(c1_w);
            end else begin
               heap_we = 1'b1;
               pos_we  = 1'b1;
            end
         end
         S_DN_CMP: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (val_lt) begin
               // smaller child moves up into the hole
               heap_wk   = ch_key_ff;
               heap_wv   = ch_val_ff;
               pos_wa    = ch_key_ff;
               slot_in   = ch_slot_ff;
               heap_rd_a = SLOT_BITS'({slot_in, 1'b1});
               heap_rd_b = SLOT_BITS'({slot_in, 1'b1} + (SLOT_BITS + 1)'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      slot_ff    <= slot_in;
      mov_key_ff <= mov_key_in;
      mov_val_ff <= mov_val_in;
      ch_key_ff  <= ch_key_in;
      ch_val_ff  <= ch_val_in;
      ch_slot_ff <= ch_slot_in;
      out_key_ff <= out_key_in;
      out_val_ff <= out_val_in;
      status_ff  <= status_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_DONE;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_value   = out_val_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = COUNT_PORT_BITS'(size_ff);

endmodule
